FILE: src/tlog_pkg.sv
// Shared types and codes for the triggered three-channel logger.
// Used by tlog_ctrl, tlog_store and triggered_three_channel_logger; no dependencies.
package tlog_pkg;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ARM  = 2'd1,
    ACT_FREE = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    MODE_FREE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_TRIG = 2'd2,
    MODE_DONE = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_TRIGGER_LEVEL = 1'b0,
    CFG_PRESCALE      = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned IndexWidth = 8;

  // Per-beat control result handed from the sequencer to the datapath.
  typedef struct packed {
    logic  we;
    logic  logged;
    mode_e mode;
  } ctrl_out_t;

endpackage

FILE: src/tlog_ctrl.sv
// Capture sequencer: mode, prescaler, trigger edge detect and write position.
// Depends on tlog_pkg.
module tlog_ctrl #(
  parameter int unsigned LOG_DEPTH        = 256,
  parameter int unsigned PRETRIGGER_DEPTH = 20,
  parameter int unsigned SAMPLE_WIDTH     = 16,
  localparam int unsigned PosWidth        = $clog2(LOG_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  tlog_pkg::action_e              action_i,
  input  logic signed [SAMPLE_WIDTH-1:0] trig_i,
  input  logic signed [tlog_pkg::CfgWidth-1:0] level_i,
  input  logic [tlog_pkg::CfgWidth-1:0]  prescale_i,
  output tlog_pkg::ctrl_out_t            ctrl_o,
  output logic [PosWidth-1:0]            wr_pos_o,
  output logic [PosWidth-1:0]            pos_next_o
);

  localparam int unsigned CntWidth = PosWidth + 9;

  tlog_pkg::mode_e                 mode_q, mode_d;
  logic signed [SAMPLE_WIDTH-1:0]  prev_q, prev_d;
  logic [tlog_pkg::CfgWidth-1:0]   skip_q, skip_d;
  logic [PosWidth-1:0]             pos_q, pos_d;

  logic [tlog_pkg::CfgWidth-1:0]   skip_inc;
  logic                            pre_fires;
  logic                            crossing;
  logic [CntWidth-1:0]             pos_inc;
  logic                            pos_at_end;
  logic                            is_tick;

  assign is_tick    = (action_i == tlog_pkg::ACT_TICK);
  assign skip_inc   = skip_q + 1'b1;
  assign pre_fires  = (skip_inc >= prescale_i);
  assign crossing   = (33'(trig_i) > 33'(level_i)) && (33'(prev_q) < 33'(level_i));
  assign pos_inc    = CntWidth'(pos_q) + 1'b1;
  assign pos_at_end = (pos_inc >= CntWidth'(LOG_DEPTH));

  // Next state
  always_comb begin
    mode_d = mode_q;
    prev_d = prev_q;
    skip_d = skip_q;
    pos_d  = pos_q;
    if (fire_i) begin
      unique case (action_i)
        tlog_pkg::ACT_TICK: begin
          prev_d = trig_i;
          if (mode_q != tlog_pkg::MODE_DONE) begin
            skip_d = pre_fires ? '0 : skip_inc;
          end
          unique case (mode_q)
            tlog_pkg::MODE_WAIT: begin
              if (crossing) begin
                mode_d = tlog_pkg::MODE_TRIG;
              end
              if (pre_fires) begin
                if (pos_at_end ||
                    (!crossing && pos_inc == CntWidth'(PRETRIGGER_DEPTH))) begin
                  pos_d = '0;
                end else begin
                  pos_d = pos_inc[PosWidth-1:0];
                end
              end
            end
            tlog_pkg::MODE_TRIG: begin
              if (pre_fires) begin
                if (pos_at_end) begin
                  pos_d  = '0;
                  mode_d = tlog_pkg::MODE_DONE;
                end else begin
                  pos_d = pos_inc[PosWidth-1:0];
                end
              end
            end
            tlog_pkg::MODE_FREE: begin
              if (pre_fires) begin
                pos_d = pos_at_end ? '0 : pos_inc[PosWidth-1:0];
              end
            end
            default: begin
            end
          endcase
        end
        tlog_pkg::ACT_ARM: begin
          mode_d = tlog_pkg::MODE_WAIT;
          pos_d  = '0;
        end
        tlog_pkg::ACT_FREE: begin
          mode_d = tlog_pkg::MODE_FREE;
          pos_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Outputs
  always_comb begin
    ctrl_o.we     = fire_i && is_tick && (mode_q != tlog_pkg::MODE_DONE) && pre_fires;
    ctrl_o.logged = ctrl_o.we;
    ctrl_o.mode   = mode_d;
    wr_pos_o      = pos_q;
    pos_next_o    = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tlog_pkg::MODE_FREE;
      prev_q <= '0;
      skip_q <= '0;
      pos_q  <= '0;
    end else begin
      mode_q <= mode_d;
      prev_q <= prev_d;
      skip_q <= skip_d;
      pos_q  <= pos_d;
    end
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntWidth'(pos_q) < CntWidth'(LOG_DEPTH))
    else $error("write position beyond store depth");

  a_done_holds_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_tick && mode_q == tlog_pkg::MODE_DONE |=>
      mode_q == tlog_pkg::MODE_DONE && $stable(pos_q) && $stable(skip_q))
    else $error("captured state left by a tick");

endmodule

FILE: src/tlog_store.sv
// Three-channel sample store: one write port, one registered read port.
// Depends on tlog_pkg for the index width.
module tlog_store #(
  parameter int unsigned LOG_DEPTH    = 256,
  parameter int unsigned SAMPLE_WIDTH = 16,
  localparam int unsigned AddrWidth   = $clog2(LOG_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AddrWidth-1:0]           waddr_i,
  input  logic [3*SAMPLE_WIDTH-1:0]      wdata_i,
  input  logic                           re_i,
  input  logic [tlog_pkg::IndexWidth-1:0] rindex_i,
  output logic                           rvalid_o,
  output logic [3*SAMPLE_WIDTH-1:0]      rdata_o
);

  localparam int unsigned ExtWidth = AddrWidth + tlog_pkg::IndexWidth;

  logic [3*SAMPLE_WIDTH-1:0] mem [LOG_DEPTH];
  logic [ExtWidth-1:0]       rindex_ext;
  logic                      in_range;
  logic [3*SAMPLE_WIDTH-1:0] rdata_q;
  logic                      rvalid_q;

  assign rindex_ext = ExtWidth'(rindex_i);
  assign in_range   = (rindex_ext < ExtWidth'(LOG_DEPTH));

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Out-of-range reads clear rvalid_q; the read data itself is not zeroed here
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q  <= mem[rindex_ext[AddrWidth-1:0]];
      rvalid_q <= in_range;
    end
  end

  assign rvalid_o = rvalid_q;
  assign rdata_o  = rdata_q;

endmodule

FILE: src/triggered_three_channel_logger.sv
// Pipeline: an input beat passes the input register, then the result register.
// Throughput: one beat per cycle while out_ready_i is high; the result register and
//   the read port of the sample store are single registers, nothing iterates.
// Reset: mode free-running, counters, position, last trigger sample and config cleared;
//   the store is not cleared, so an entry reads as garbage until first written.
module triggered_three_channel_logger #(
  parameter int unsigned LOG_DEPTH        = 256,
  parameter int unsigned PRETRIGGER_DEPTH = 20,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [tlog_pkg::CfgWidth-1:0]  cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ch1_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ch2_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ch3_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] trigger_sample_i,
  input  logic [tlog_pkg::IndexWidth-1:0] read_index_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     capture_state_o,
  output logic [tlog_pkg::IndexWidth-1:0] next_index_o,
  output logic                           logged_o,
  output logic signed [SAMPLE_WIDTH-1:0] read_ch1_o,
  output logic signed [SAMPLE_WIDTH-1:0] read_ch2_o,
  output logic signed [SAMPLE_WIDTH-1:0] read_ch3_o
);

  localparam int unsigned PosWidth = $clog2(LOG_DEPTH);
  localparam int unsigned IdxExt   = PosWidth + tlog_pkg::IndexWidth;

  // Configuration registers
  logic signed [tlog_pkg::CfgWidth-1:0] trigger_level_q;
  logic [tlog_pkg::CfgWidth-1:0]        prescale_q;

  // Input register stage
  logic                           s1_valid_q, s1_valid_d;
  tlog_pkg::action_e              s1_action_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_ch1_q, s1_ch2_q, s1_ch3_q, s1_trig_q;
  logic [tlog_pkg::IndexWidth-1:0] s1_ridx_q;

  // Result register stage
  logic                            out_valid_q, out_valid_d;
  tlog_pkg::mode_e                 out_mode_q;
  logic [tlog_pkg::IndexWidth-1:0] out_index_q;
  logic                            out_logged_q;
  logic                            out_rd_q;

  logic                            in_accept;
  logic                            out_adv;
  logic                            fire;
  logic                            is_read;
  tlog_pkg::ctrl_out_t             ctrl;
  logic [PosWidth-1:0]             wr_pos;
  logic [PosWidth-1:0]             pos_next;
  logic [IdxExt-1:0]               pos_next_ext;
  logic                            rvalid;
  logic [3*SAMPLE_WIDTH-1:0]       rdata;

  // ---------------------------------------------------------------------------
  // Configuration: always ready; the user must write it only while the block is idle, the block does not enforce it.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_level_q <= '0;
      prescale_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (tlog_pkg::cfg_idx_e'(cfg_index_i))
        tlog_pkg::CFG_TRIGGER_LEVEL: trigger_level_q <= cfg_data_i;
        tlog_pkg::CFG_PRESCALE:      prescale_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the input register advances whenever the result register is
  // empty or being drained; a result left waiting holds the beat in the input register.
  // ---------------------------------------------------------------------------
  assign out_adv    = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && out_adv;
  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until the beat moves on
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= tlog_pkg::action_e'(action_i);
      s1_ch1_q    <= ch1_sample_i;
      s1_ch2_q    <= ch2_sample_i;
      s1_ch3_q    <= ch3_sample_i;
      s1_trig_q   <= trigger_sample_i;
      s1_ridx_q   <= read_index_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: all mode, prescaler and position updates happen on fire.
  // ---------------------------------------------------------------------------
  tlog_ctrl #(
    .LOG_DEPTH        (LOG_DEPTH),
    .PRETRIGGER_DEPTH (PRETRIGGER_DEPTH),
    .SAMPLE_WIDTH     (SAMPLE_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .action_i   (s1_action_q),
    .trig_i     (s1_trig_q),
    .level_i    (trigger_level_q),
    .prescale_i (prescale_q),
    .ctrl_o     (ctrl),
    .wr_pos_o   (wr_pos),
    .pos_next_o (pos_next)
  );

  // ---------------------------------------------------------------------------
  // Store: write at the current position, read into its own output register.
  // A write lands at the same edge the beat leaves, so the following beat
  // already reads the new entry.
  // ---------------------------------------------------------------------------
  assign is_read = (s1_action_q == tlog_pkg::ACT_READ);

  tlog_store #(
    .LOG_DEPTH    (LOG_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (ctrl.we),
    .waddr_i  (wr_pos),
    .wdata_i  ({s1_ch3_q, s1_ch2_q, s1_ch1_q}),
    .re_i     (fire && is_read),
    .rindex_i (s1_ridx_q),
    .rvalid_o (rvalid),
    .rdata_o  (rdata)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  assign pos_next_ext = IdxExt'(pos_next);

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_mode_q   <= ctrl.mode;
      out_index_q  <= pos_next_ext[tlog_pkg::IndexWidth-1:0];
      out_logged_q <= ctrl.logged;
      out_rd_q     <= is_read;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign capture_state_o = out_mode_q;
  assign next_index_o    = out_index_q;
  assign logged_o        = out_logged_q;

  // Drop read data to zero for anything but an in-range read
  always_comb begin
    if (out_rd_q && rvalid) begin
      read_ch1_o = rdata[SAMPLE_WIDTH-1:0];
      read_ch2_o = rdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      read_ch3_o = rdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
    end else begin
      read_ch1_o = '0;
      read_ch2_o = '0;
      read_ch3_o = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled with empty input register");

  a_stalled_beat_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !fire |=> s1_valid_q && $stable(s1_action_q))
    else $error("stalled beat lost from input register");

  a_logged_not_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && logged_o |-> !out_rd_q)
    else $error("read beat marked as logged");

  a_write_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.we |-> fire && s1_action_q == tlog_pkg::ACT_TICK)
    else $error("store written outside a sample tick");

endmodule

FILE: bench/tlog_result_check.sv
// Result checker for the triggered three-channel logger testbench.
// Watches the config, input and result channels, predicts every result beat
// and compares it field by field. Depends on tlog_pkg only.
`timescale 1ns / 1ps

module tlog_result_check #(
  parameter int unsigned LOG_DEPTH        = 256,
  parameter int unsigned PRETRIGGER_DEPTH = 20,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic                           cfg_index_i,
  input  logic [tlog_pkg::CfgWidth-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [1:0]                     action_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ch1_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ch2_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] ch3_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] trigger_sample_i,
  input  logic [tlog_pkg::IndexWidth-1:0] read_index_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [1:0]                     capture_state_i,
  input  logic [tlog_pkg::IndexWidth-1:0] next_index_i,
  input  logic                           logged_i,
  input  logic signed [SAMPLE_WIDTH-1:0] read_ch1_i,
  input  logic signed [SAMPLE_WIDTH-1:0] read_ch2_i,
  input  logic signed [SAMPLE_WIDTH-1:0] read_ch3_i,
  output int unsigned                    error_count_o,
  output int unsigned                    pending_o,
  output int unsigned                    checked_o,
  output int unsigned                    captures_o
);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    tlog_pkg::mode_e                 state;
    logic [tlog_pkg::IndexWidth-1:0] index;
    logic                            logged;
    sample_t                         c1;
    sample_t                         c2;
    sample_t                         c3;
  } log_result_t;

  // Predictor copy of the logger
  sample_t         cfg_level;
  logic [15:0]     cfg_prescale;
  tlog_pkg::mode_e cur_mode;
  sample_t         last_trig;
  logic [15:0]     tick_count;
  int unsigned     wr_ptr;
  sample_t         mem_c1 [LOG_DEPTH];
  sample_t         mem_c2 [LOG_DEPTH];
  sample_t         mem_c3 [LOG_DEPTH];

  log_result_t     expected_results [$];

  function automatic log_result_t logger_step(tlog_pkg::action_e act, sample_t s1,
                                              sample_t s2, sample_t s3, sample_t trig,
                                              logic [tlog_pkg::IndexWidth-1:0] ridx);
    log_result_t     r;
    tlog_pkg::mode_e entry_mode;
    logic            fire;
    r          = '0;
    fire       = 1'b0;
    entry_mode = cur_mode;
    case (act)
      tlog_pkg::ACT_TICK: begin
        if (cur_mode != tlog_pkg::MODE_DONE) begin
          // strict crossing: equal on either side does not count
          if (cur_mode == tlog_pkg::MODE_WAIT && trig > cfg_level && last_trig < cfg_level)
            cur_mode = tlog_pkg::MODE_TRIG;
          tick_count = tick_count + 16'd1;
          if (tick_count >= cfg_prescale) begin
            tick_count = '0;
            fire       = 1'b1;
          end
        end
        if (fire) begin
          mem_c1[wr_ptr] = s1;
          mem_c2[wr_ptr] = s2;
          mem_c3[wr_ptr] = s3;
          r.logged       = 1'b1;
          case (entry_mode)
            tlog_pkg::MODE_WAIT: begin
              wr_ptr++;
              if (wr_ptr >= LOG_DEPTH ||
                  (wr_ptr == PRETRIGGER_DEPTH && cur_mode == tlog_pkg::MODE_WAIT))
                wr_ptr = 0;
            end
            tlog_pkg::MODE_TRIG: begin
              wr_ptr++;
              if (wr_ptr >= LOG_DEPTH) begin
                wr_ptr   = 0;
                cur_mode = tlog_pkg::MODE_DONE;
                captures_o++;
              end
            end
            default: wr_ptr = (wr_ptr >= LOG_DEPTH - 1) ? 0 : wr_ptr + 1;
          endcase
        end
        last_trig = trig;
      end
      tlog_pkg::ACT_ARM: begin
        cur_mode = tlog_pkg::MODE_WAIT;
        wr_ptr   = 0;
      end
      tlog_pkg::ACT_FREE: begin
        cur_mode = tlog_pkg::MODE_FREE;
        wr_ptr   = 0;
      end
      default: begin
        if (ridx < LOG_DEPTH) begin
          r.c1 = mem_c1[ridx];
          r.c2 = mem_c2[ridx];
          r.c3 = mem_c3[ridx];
        end
      end
    endcase
    r.state = cur_mode;
    r.index = tlog_pkg::IndexWidth'(wr_ptr);
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      error_count_o++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    log_result_t want;
    log_result_t got;
    if (!rst_ni) begin
      cfg_level     = '0;
      cfg_prescale  = '0;
      cur_mode      = tlog_pkg::MODE_FREE;
      last_trig     = '0;
      tick_count    = '0;
      wr_ptr        = 0;
      expected_results.delete();
      error_count_o = 0;
      pending_o     = 0;
      checked_o     = 0;
      captures_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tlog_pkg::CFG_TRIGGER_LEVEL) cfg_level = sample_t'(cfg_data_i);
        else cfg_prescale = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        got.state  = tlog_pkg::mode_e'(capture_state_i);
        got.index  = next_index_i;
        got.logged = logged_i;
        got.c1     = read_ch1_i;
        got.c2     = read_ch2_i;
        got.c3     = read_ch3_i;
        checked_o++;
        if (expected_results.size() == 0) begin
          error_count_o++;
          $display("%0t: result beat with nothing expected, actual state %0d index %0d",
                   $time, got.state, got.index);
        end else begin
          want = expected_results.pop_front();
          check_field("capture_state", 16'(want.state), 16'(got.state));
          check_field("next_index", 16'(want.index), 16'(got.index));
          check_field("logged", 16'(want.logged), 16'(got.logged));
          check_field("read_ch1", want.c1, got.c1);
          check_field("read_ch2", want.c2, got.c2);
          check_field("read_ch3", want.c3, got.c3);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(logger_step(tlog_pkg::action_e'(action_i), ch1_sample_i,
                                               ch2_sample_i, ch3_sample_i,
                                               trigger_sample_i, read_index_i));
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: bench/tb_triggered_three_channel_logger.sv
// Top of the triggered three-channel logger testbench: clock, reset, stimulus,
// back-pressure and verdict. Depends on tlog_pkg, tlog_result_check and
// triggered_three_channel_logger.
`timescale 1ns / 1ps

module tb_triggered_three_channel_logger;

  typedef logic signed [15:0] sample_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_valid;
  logic                            cfg_ready;
  tlog_pkg::cfg_idx_e              cfg_index;
  logic [tlog_pkg::CfgWidth-1:0]   cfg_data;
  logic                            in_valid;
  logic                            in_ready;
  logic [1:0]                      action;
  sample_t                         ch1, ch2, ch3, trig;
  logic [tlog_pkg::IndexWidth-1:0] read_idx;
  logic                            out_valid;
  logic                            out_ready;
  logic [1:0]                      cap_state;
  logic [tlog_pkg::IndexWidth-1:0] next_idx;
  logic                            logged;
  sample_t                         rd1, rd2, rd3;

  int unsigned err_cnt, pend_cnt, chk_cnt, cap_cnt;
  int unsigned items_sent, reads_sent;

  // steady: no idling on either side; squeeze_req: ask the receiver for a long hold-off
  bit steady;
  bit squeeze_req;

  triggered_three_channel_logger i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .action_i        (action),
    .ch1_sample_i    (ch1),
    .ch2_sample_i    (ch2),
    .ch3_sample_i    (ch3),
    .trigger_sample_i(trig),
    .read_index_i    (read_idx),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .capture_state_o (cap_state),
    .next_index_o    (next_idx),
    .logged_o        (logged),
    .read_ch1_o      (rd1),
    .read_ch2_o      (rd2),
    .read_ch3_o      (rd3)
  );

  tlog_result_check i_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .action_i        (action),
    .ch1_sample_i    (ch1),
    .ch2_sample_i    (ch2),
    .ch3_sample_i    (ch3),
    .trigger_sample_i(trig),
    .read_index_i    (read_idx),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .capture_state_i (cap_state),
    .next_index_i    (next_idx),
    .logged_i        (logged),
    .read_ch1_i      (rd1),
    .read_ch2_i      (rd2),
    .read_ch3_i      (rd3),
    .error_count_o   (err_cnt),
    .pending_o       (pend_cnt),
    .checked_o       (chk_cnt),
    .captures_o      (cap_cnt)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up long after the slowest correct run would have finished
  initial begin
    #2_000_000;
    $display("tb_triggered_three_channel_logger: errors");
    $finish;
  end

  // Result receiver: drop ready about 11 times in a hundred, never while steady,
  // and hold it low for a long count when asked so the block backs up.
  initial begin
    int squeeze_left;
    squeeze_left = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req  = 1'b0;
        squeeze_left = 64;
      end
      if (squeeze_left > 0) begin
        squeeze_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  // Offer one input beat; hold valid and payload until the block takes it.
  task automatic send_beat(input tlog_pkg::action_e act, input sample_t s1, s2, s3, tr,
                           input logic [tlog_pkg::IndexWidth-1:0] idx);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    ch1      <= s1;
    ch2      <= s2;
    ch3      <= s3;
    trig     <= tr;
    read_idx <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (act == tlog_pkg::ACT_READ) reads_sent++;
  endtask

  // Beat with random channel samples and read index; only action and trigger chosen.
  task automatic send_rand(input tlog_pkg::action_e act, input sample_t tr);
    send_beat(act, sample_t'($urandom), sample_t'($urandom), sample_t'($urandom), tr,
              tlog_pkg::IndexWidth'($urandom));
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline drain.
  task automatic quiesce();
    int spin;
    spin = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pend_cnt != 0 && spin < 5000) begin
      @(negedge clk);
      spin++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input tlog_pkg::cfg_idx_e idx,
                           input logic [tlog_pkg::CfgWidth-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Registers are only touched while the logger is idle.
  task automatic set_config(input int level, input logic [15:0] presc);
    quiesce();
    write_reg(tlog_pkg::CFG_TRIGGER_LEVEL, tlog_pkg::CfgWidth'(level));
    write_reg(tlog_pkg::CFG_PRESCALE, presc);
  endtask

  // Well-formed capture: arm, fill the pre-trigger ring below the level, cross it,
  // then tick on until the store is full and read some entries back.
  // Expects a prescale of 0 or 1 and a level well inside the range.
  task automatic run_capture(input int level, input bit squeeze);
    int ticks;
    bit squeezed;
    squeezed = 1'b0;
    send_rand(tlog_pkg::ACT_ARM, sample_t'($urandom));
    repeat ($urandom_range(45, 3))
      send_rand(tlog_pkg::ACT_TICK,
                sample_t'(level - 1 - int'($urandom_range(level + 32767))));
    send_rand(tlog_pkg::ACT_TICK, sample_t'(level + 1 + int'($urandom_range(32766 - level))));
    ticks = 0;
    while (ticks < 262) begin
      if ($urandom_range(99) < 8) begin
        send_rand(tlog_pkg::ACT_READ, sample_t'($urandom));
      end else begin
        send_rand(tlog_pkg::ACT_TICK, sample_t'($urandom));
        ticks++;
      end
      // once 100 ticks are in, back the result side up while beats keep coming
      if (squeeze && !squeezed && ticks == 100) begin
        squeeze_req = 1'b1;
        squeezed    = 1'b1;
      end
    end
    repeat (6) send_rand(tlog_pkg::ACT_READ, sample_t'($urandom));
    send_rand(tlog_pkg::ACT_FREE, sample_t'($urandom));
  endtask

  // Loose mix of all actions; triggers often land close to the level.
  task automatic run_mixed(input int n, input int level);
    int      pick;
    int      v;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        if ($urandom_range(99) < 30) begin
          v = level + int'($urandom_range(6)) - 3;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end else begin
          v = int'(sample_t'($urandom));
        end
        send_rand(tlog_pkg::ACT_TICK, sample_t'(v));
      end else if (pick < 68) begin
        send_rand(tlog_pkg::ACT_ARM, sample_t'($urandom));
      end else if (pick < 76) begin
        send_rand(tlog_pkg::ACT_FREE, sample_t'($urandom));
      end else begin
        send_rand(tlog_pkg::ACT_READ, sample_t'($urandom));
      end
    end
  endtask

  initial begin
    int lvl;
    cfg_valid   = 1'b0;
    cfg_index   = tlog_pkg::CFG_TRIGGER_LEVEL;
    cfg_data    = '0;
    in_valid    = 1'b0;
    action      = tlog_pkg::ACT_TICK;
    ch1         = '0;
    ch2         = '0;
    ch3         = '0;
    trig        = '0;
    read_idx    = '0;
    steady      = 1'b0;
    squeeze_req = 1'b0;
    items_sent  = 0;
    reads_sent  = 0;
    rst_n       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_config(0, 16'd0);

    // Fill the whole store in free-run so that any later read hits a written entry;
    // 256 ticks also wraps the position from the top back to zero.
    repeat (256) send_rand(tlog_pkg::ACT_TICK, sample_t'($urandom));

    // Directed: sample extremes, every action, crossing corner cases, arm from free, wait and trig
    steady = 1'b1;
    send_beat(tlog_pkg::ACT_TICK, 16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000, 8'h00);
    send_beat(tlog_pkg::ACT_TICK, 16'sh8000, 16'sh7fff, 16'shffff, 16'sh7fff, 8'hff);
    send_beat(tlog_pkg::ACT_READ, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'h00);
    send_beat(tlog_pkg::ACT_READ, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 8'h01);
    send_beat(tlog_pkg::ACT_READ, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 8'hff);
    send_rand(tlog_pkg::ACT_FREE, sample_t'($urandom));
    send_rand(tlog_pkg::ACT_ARM, sample_t'($urandom));
    send_rand(tlog_pkg::ACT_ARM, sample_t'($urandom));
    send_rand(tlog_pkg::ACT_TICK, -16'sd1);
    send_rand(tlog_pkg::ACT_TICK, 16'sd0);       // equal to the level: no trigger
    send_rand(tlog_pkg::ACT_TICK, 16'sd1);       // previous sat on the level: no trigger
    send_rand(tlog_pkg::ACT_TICK, 16'sh8000);
    send_rand(tlog_pkg::ACT_TICK, 16'sh7fff);    // true rising crossing
    send_rand(tlog_pkg::ACT_TICK, sample_t'($urandom));
    send_rand(tlog_pkg::ACT_READ, sample_t'($urandom));
    send_rand(tlog_pkg::ACT_ARM, sample_t'($urandom));
    send_rand(tlog_pkg::ACT_FREE, sample_t'($urandom));
    send_rand(tlog_pkg::ACT_TICK, 16'sh8000);
    send_rand(tlog_pkg::ACT_READ, sample_t'($urandom));
    steady = 1'b0;

    // Full capture with a long result hold-off in the middle
    run_capture(0, 1'b1);

    // Level at the bottom: nothing can ever cross it
    set_config(-32768, 16'd1);
    run_mixed(50, -32768);

    // Level at the top, no idling on either side for the whole stretch
    set_config(32767, 16'd0);
    steady = 1'b1;
    run_mixed(60, 32767);
    steady = 1'b0;

    // Second capture at a random level, prescale of one
    lvl = int'($urandom_range(40000)) - 20000;
    set_config(lvl, 16'd1);
    run_capture(lvl, 1'b0);

    // Prescaler actually skipping ticks; counter carried across arm
    lvl = int'(sample_t'($urandom));
    set_config(lvl, 16'd3);
    run_mixed(50, lvl);

    lvl = int'(sample_t'($urandom));
    set_config(lvl, 16'd2);
    run_mixed(40, lvl);

    // Largest prescale, then a random one to exercise the upper bits
    lvl = int'(sample_t'($urandom));
    set_config(lvl, 16'hffff);
    run_mixed(20, lvl);

    lvl = int'(sample_t'($urandom));
    set_config(lvl, 16'($urandom));
    run_mixed(20, lvl);

    quiesce();

    $display("Covered %0d input beats (%0d reads), %0d results checked, %0d full captures.",
             items_sent, reads_sent, chk_cnt, cap_cnt);
    if (pend_cnt != 0)
      $display("%0t: %0d expected results never arrived", $time, pend_cnt);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("tb_triggered_three_channel_logger: clean");
    end else begin
      $display("tb_triggered_three_channel_logger: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/tlog_pkg.sv
src/tlog_ctrl.sv
src/tlog_store.sv
src/triggered_three_channel_logger.sv
bench/tlog_result_check.sv
bench/tb_triggered_three_channel_logger.sv
